/* rtl/core/tfdd_pkg.sv */
// Shared types, constants and helpers of the trail field diffuse/decay unit.
package tfdd_pkg;

   // Grid geometry
   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 64;
   localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_AW     = $clog2(CELL_COUNT);
   localparam int COL_W       = $clog2(GRID_WIDTH);
   localparam int ROW_W       = $clog2(GRID_HEIGHT);
   // stream row counter covers the wrap rows before and after the grid
   localparam int SROW_W      = $clog2(GRID_HEIGHT + 2);
   // two full rows plus one cell of history for the 5-point stencil
   localparam int LINE_DEPTH  = 2 * GRID_WIDTH + 1;

   // Field widths
   localparam int CELL_W  = 16;
   localparam int COORD_W = 7;
   localparam int COUNT_W = 13;
   localparam int GAIN_W  = 9;
   localparam int DECAY_W = 14;

   // Register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [CELL_W-1:0]  CELL_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [GAIN_W-1:0]  GAIN_RESET   = GAIN_W'(128);
   localparam logic [DECAY_W-1:0] DECAY_RESET  = DECAY_W'(328);
   localparam logic [CELL_W-1:0]  THRESH_RESET = CELL_W'(11796);

   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_DEPOSIT = 2'd1,
      CMD_PASS    = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_GAIN   = 2'd0,
      CSR_DECAY  = 2'd1,
      CSR_THRESH = 2'd2
   } csr_index_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [COORD_W-1:0]   x_coord;
      logic [COORD_W-1:0]   y_coord;
      logic [CELL_W-1:0]    deposit_amount;
   } req_word_type;

   typedef struct packed {
      logic [CELL_W-1:0]    cell_value;
      logic [COUNT_W-1:0]   filled_count;
      logic                 out_of_range;
   } rsp_word_type;

   typedef struct packed {
      logic [GAIN_W-1:0]    diffuse_gain;
      logic [DECAY_W-1:0]   decay_amount;
      logic [CELL_W-1:0]    coverage_threshold;
   } cfg_type;

   // Datapath operations issued by the controller, one per cycle
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_ACC_CHECK,
      DP_ACC_DONE,
      DP_ZERO,
      DP_STREAM,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type            op;
      logic [SROW_W-1:0]    row;      // source row of a sweep access
      logic [COL_W-1:0]     col;      // column of a sweep access
      logic                 emit;     // stream read completes a stencil
      logic [ROW_W-1:0]     out_row;  // row of the cell that stencil produces
      logic                 respond;  // last zero write of a clear
   } dp_cmd_type;

   typedef struct packed {
      logic oor;
      logic pipe_busy;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ACCESS,
      ST_ACC_DONE,
      ST_CLEAR,
      ST_STREAM,
      ST_DRAIN
   } ctrl_state_type;

   // Linear memory address of a cell
   function automatic logic [CELL_AW-1:0] cell_index(input int row, input int col);
      return CELL_AW'(row * GRID_WIDTH + col);
   endfunction

endpackage

/* rtl/core/tfdd_csr.sv */
// Configuration registers behind the APB-style port.
module tfdd_csr
   import tfdd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [DECAY_W-1:0] decay_ff, decay_in;
   logic [CELL_W-1:0]  thresh_ff, thresh_in;
   logic               wr_en;
   logic [1:0]         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[3:2];

   // Write decode
   always_comb begin
      gain_in   = gain_ff;
      decay_in  = decay_ff;
      thresh_in = thresh_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_GAIN:   gain_in   = pwdata[GAIN_W-1:0];
            CSR_DECAY:  decay_in  = pwdata[DECAY_W-1:0];
            CSR_THRESH: thresh_in = pwdata[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         decay_ff  <= DECAY_RESET;
         thresh_ff <= THRESH_RESET;
      end else begin
         gain_ff   <= gain_in;
         decay_ff  <= decay_in;
         thresh_ff <= thresh_in;
      end
   end

   // Read decode
   always_comb begin
      unique case (reg_sel)
         CSR_GAIN:   prdata = CSR_DW'(gain_ff);
         CSR_DECAY:  prdata = CSR_DW'(decay_ff);
         CSR_THRESH: prdata = CSR_DW'(thresh_ff);
         default:    prdata = '0;
      endcase
   end

   assign cfg.diffuse_gain       = gain_ff;
   assign cfg.decay_amount       = decay_ff;
   assign cfg.coverage_threshold = thresh_ff;

endmodule

/* rtl/core/tfdd_ctrl.sv */
// Command sequencer: decodes words, runs the sweep counters, drives the datapath.
module tfdd_ctrl
   import tfdd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  cmd_type       req_cmd,
   output logic          busy,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   ctrl_state_type    state_ff, state_in;
   logic [SROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;

   logic              col_last;
   logic              grid_row_last;
   logic              stream_row_last;
   logic [COL_W-1:0]  col_next;
   logic [SROW_W-1:0] row_next;
   logic [SROW_W-1:0] src_row;

   // Raster counters shared by clear, init and stream sweeps
   assign col_last        = (col_ff == COL_W'(GRID_WIDTH - 1));
   assign grid_row_last   = (row_ff == SROW_W'(GRID_HEIGHT - 1));
   assign stream_row_last = (row_ff == SROW_W'(GRID_HEIGHT + 1));
   assign col_next        = col_last ? '0 : col_ff + 1'b1;
   assign row_next        = col_last ? row_ff + 1'b1 : row_ff;

   // Stream order: last row, rows 0..H-1, then row 0 again for the bottom wrap
   always_comb begin
      if (row_ff == '0) begin
         src_row = SROW_W'(GRID_HEIGHT - 1);
      end else if (stream_row_last) begin
         src_row = '0;
      end else begin
         src_row = row_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      dp_cmd   = '0;
      dp_cmd.op = DP_NOP;
      unique case (state_ff)
         ST_INIT: begin
            // zero bank a after reset
            dp_cmd.op  = DP_ZERO;
            dp_cmd.row = row_ff;
            dp_cmd.col = col_ff;
            row_in     = row_next;
            col_in     = col_next;
            if (col_last && grid_row_last) begin
               state_in = ST_IDLE;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_IDLE: begin
            if (start) begin
               dp_cmd.op = DP_LOAD;
               row_in    = '0;
               col_in    = '0;
               unique case (req_cmd) inside
                  CMD_READ, CMD_DEPOSIT: state_in = ST_ACCESS;
                  CMD_PASS:              state_in = ST_STREAM;
                  CMD_CLEAR:             state_in = ST_CLEAR;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACCESS: begin
            dp_cmd.op = DP_ACC_CHECK;
            state_in  = dp_status.oor ? ST_IDLE : ST_ACC_DONE;
         end
         ST_ACC_DONE: begin
            dp_cmd.op = DP_ACC_DONE;
            state_in  = ST_IDLE;
         end
         ST_CLEAR: begin
            dp_cmd.op      = DP_ZERO;
            dp_cmd.row     = row_ff;
            dp_cmd.col     = col_ff;
            dp_cmd.respond = col_last && grid_row_last;
            row_in         = row_next;
            col_in         = col_next;
            if (col_last && grid_row_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_STREAM: begin
            dp_cmd.op      = DP_STREAM;
            dp_cmd.row     = src_row;
            dp_cmd.col     = col_ff;
            dp_cmd.emit    = (row_ff >= SROW_W'(2));
            dp_cmd.out_row = ROW_W'(row_ff - SROW_W'(2));
            row_in         = row_next;
            col_in         = col_next;
            if (col_last && stream_row_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dp_status.pipe_busy) begin
               dp_cmd.op = DP_FINISH;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/core/tfdd_datapath.sv */
// Field banks, stencil line buffer, diffuse/decay pipeline and result register.
module tfdd_datapath
   import tfdd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   input  req_word_type  req_word,
   input  cfg_type       cfg,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word
);

   // Two field banks, ping-ponged by active_bank_ff
   logic [CELL_W-1:0] bank_a_mem [CELL_COUNT];
   logic [CELL_W-1:0] bank_b_mem [CELL_COUNT];
   logic [CELL_W-1:0] a_rdata_ff, b_rdata_ff;
   logic              active_bank_ff, active_bank_in;

   req_word_type      req_ff;
   logic              oor;
   logic [CELL_AW-1:0] acc_addr;
   logic [CELL_AW-1:0] sweep_addr;

   logic               rd_en;
   logic [CELL_AW-1:0] rd_addr;
   logic [CELL_W-1:0]  rdata;

   logic               live_we, spare_we;
   logic [CELL_AW-1:0] live_waddr, spare_waddr;
   logic [CELL_W-1:0]  live_wdata, spare_wdata;
   logic               a_we, b_we;
   logic [CELL_AW-1:0] a_waddr, b_waddr;
   logic [CELL_W-1:0]  a_wdata, b_wdata;

   logic [CELL_W:0]    dep_sum;
   logic [CELL_W-1:0]  acc_value;
   logic               dep_wr;

   // Stencil pipeline
   logic [CELL_W-1:0]  line_ff [LINE_DEPTH];
   logic               s1_valid_ff, s1_emit_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic               s2_valid_ff;
   logic [COL_W-1:0]   s2_col_ff;
   logic [ROW_W-1:0]   s2_row_ff;
   logic               s3_valid_ff;
   logic [CELL_W-1:0]  s3_c_ff, s3_blur_ff;
   logic [CELL_AW-1:0] s3_addr_ff;
   logic               s4_valid_ff;
   logic signed [26:0] s4_prod_ff;
   logic [CELL_W-1:0]  s4_c_ff;
   logic [CELL_AW-1:0] s4_addr_ff;

   logic [CELL_W-1:0]  st_c, st_l, st_r, st_u, st_d;
   logic [CELL_W+2:0]  st_sum;
   logic signed [16:0] mix_diff;
   logic signed [26:0] mix_prod;
   logic signed [26:0] prod_shr;
   logic signed [19:0] mix_full;
   logic [CELL_W-1:0]  mix_value;

   logic [COUNT_W-1:0] filled_ff, filled_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   // Request word latch
   always_ff @(posedge clock) begin
      if (dp_cmd.op == DP_LOAD) begin
         req_ff <= req_word;
      end
   end

   assign oor = (int'(req_ff.x_coord) >= GRID_WIDTH) ||
                (int'(req_ff.y_coord) >= GRID_HEIGHT);
   assign acc_addr   = cell_index(int'(req_ff.y_coord), int'(req_ff.x_coord));
   assign sweep_addr = cell_index(int'(dp_cmd.row), int'(dp_cmd.col));

   // Read port of the live bank
   assign rd_en   = (dp_cmd.op == DP_STREAM) || ((dp_cmd.op == DP_ACC_CHECK) && !oor);
   assign rd_addr = (dp_cmd.op == DP_STREAM) ? sweep_addr : acc_addr;
   assign rdata   = active_bank_ff ? b_rdata_ff : a_rdata_ff;

   // Deposit saturation
   assign dep_sum   = {1'b0, rdata} + {1'b0, req_ff.deposit_amount};
   assign dep_wr    = (dp_cmd.op == DP_ACC_DONE) && (req_ff.cmd == CMD_DEPOSIT);
   always_comb begin
      if (req_ff.cmd == CMD_DEPOSIT) begin
         acc_value = dep_sum[CELL_W] ? CELL_MAX : dep_sum[CELL_W-1:0];
      end else begin
         acc_value = rdata;
      end
   end

   // Live bank takes deposits and zero sweeps, spare bank takes pass results
   assign live_we     = dep_wr || (dp_cmd.op == DP_ZERO);
   assign live_waddr  = (dp_cmd.op == DP_ZERO) ? sweep_addr : acc_addr;
   assign live_wdata  = (dp_cmd.op == DP_ZERO) ? '0 : acc_value;
   assign spare_we    = s4_valid_ff;
   assign spare_waddr = s4_addr_ff;
   assign spare_wdata = mix_value;

   assign a_we    = active_bank_ff ? spare_we    : live_we;
   assign a_waddr = active_bank_ff ? spare_waddr : live_waddr;
   assign a_wdata = active_bank_ff ? spare_wdata : live_wdata;
   assign b_we    = active_bank_ff ? live_we     : spare_we;
   assign b_waddr = active_bank_ff ? live_waddr  : spare_waddr;
   assign b_wdata = active_bank_ff ? live_wdata  : spare_wdata;

   always_ff @(posedge clock) begin
      if (a_we) begin
         bank_a_mem[a_waddr] <= a_wdata;
      end
      if (rd_en && !active_bank_ff) begin
         a_rdata_ff <= bank_a_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bank_b_mem[b_waddr] <= b_wdata;
      end
      if (rd_en && active_bank_ff) begin
         b_rdata_ff <= bank_b_mem[rd_addr];
      end
   end

   assign active_bank_in = (dp_cmd.op == DP_FINISH) ? !active_bank_ff : active_bank_ff;

   // Pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         active_bank_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
      end else begin
         active_bank_ff <= active_bank_in;
         s1_valid_ff    <= (dp_cmd.op == DP_STREAM);
         s2_valid_ff    <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff    <= s2_valid_ff;
         s4_valid_ff    <= s3_valid_ff;
      end
   end

   // Stream tags, aligned with the read data
   always_ff @(posedge clock) begin
      s1_emit_ff <= dp_cmd.emit;
      s1_col_ff  <= dp_cmd.col;
      s1_row_ff  <= dp_cmd.out_row;
      s2_col_ff  <= s1_col_ff;
      s2_row_ff  <= s1_row_ff;
   end

   // Line buffer: two rows plus one cell of the raster stream
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_ff[0] <= rdata;
         for (int i = 1; i < LINE_DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   // Stencil taps, with horizontal wrap at both row ends
   assign st_d = line_ff[0];
   assign st_c = line_ff[GRID_WIDTH];
   assign st_u = line_ff[2*GRID_WIDTH];
   assign st_l = (s2_col_ff == '0) ? line_ff[1] : line_ff[GRID_WIDTH+1];
   assign st_r = (s2_col_ff == COL_W'(GRID_WIDTH - 1)) ? line_ff[2*GRID_WIDTH-1]
                                                        : line_ff[GRID_WIDTH-1];
   assign st_sum = {1'b0, st_c, 2'b00} + (CELL_W+3)'(st_l) + (CELL_W+3)'(st_r)
                 + (CELL_W+3)'(st_u) + (CELL_W+3)'(st_d);

   always_ff @(posedge clock) begin
      s3_c_ff    <= st_c;
      s3_blur_ff <= st_sum[CELL_W+2:3];
      s3_addr_ff <= cell_index(int'(s2_row_ff), int'(s2_col_ff));
   end

   // Blend toward blur
   assign mix_diff = $signed({1'b0, s3_blur_ff}) - $signed({1'b0, s3_c_ff});
   assign mix_prod = mix_diff * $signed({1'b0, cfg.diffuse_gain});

   always_ff @(posedge clock) begin
      s4_prod_ff <= mix_prod;
      s4_c_ff    <= s3_c_ff;
      s4_addr_ff <= s3_addr_ff;
   end

   // Floor shift, decay and clamp
   assign prod_shr = s4_prod_ff >>> 8;
   assign mix_full = $signed({4'b0, s4_c_ff}) + $signed(prod_shr[19:0])
                   - $signed({6'b0, cfg.decay_amount});
   always_comb begin
      if (mix_full < 0) begin
         mix_value = '0;
      end else if (mix_full > $signed({4'b0, CELL_MAX})) begin
         mix_value = CELL_MAX;
      end else begin
         mix_value = mix_full[CELL_W-1:0];
      end
   end

   // Coverage count
   always_comb begin
      filled_in = filled_ff;
      if (dp_cmd.op == DP_LOAD) begin
         filled_in = '0;
      end else if (s4_valid_ff && (mix_value >= cfg.coverage_threshold) &&
                   (filled_ff != COUNT_MAX)) begin
         filled_in = filled_ff + 1'b1;
      end
   end

   // Result word
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (dp_cmd.op)
         DP_ACC_CHECK: begin
            rsp_valid_in        = oor;
            rsp_in.out_of_range = oor;
         end
         DP_ACC_DONE: begin
            rsp_valid_in      = 1'b1;
            rsp_in.cell_value = acc_value;
         end
         DP_ZERO: begin
            rsp_valid_in = dp_cmd.respond;
         end
         DP_FINISH: begin
            rsp_valid_in        = 1'b1;
            rsp_in.filled_count = filled_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign dp_status.oor       = oor;
   assign dp_status.pipe_busy = s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff;

endmodule

/* rtl/core/trail_field_diffuse_decay_unit.sv */
// Top level of the trail field diffuse/decay unit.
//
// A word is taken when start is high and busy is low; every word yields one
// result, shown on rsp_word for a single cycle with rsp_valid high, registered
// in the cycle after the command's last step. The receiver cannot stall, so
// results must be captured on that cycle. A read or deposit does one field
// read, then the saturating write for a deposit, and then gives its result;
// with coordinates off the grid the result comes straight from the range
// check, since the field is not touched. A clear does one zero write per
// cycle over all GRID_WIDTH*GRID_HEIGHT cells. A diffuse/decay pass reads the
// live bank once per cycle in raster order, since the live bank has a single
// read port, with the last row before and row 0 after the grid for the
// vertical wrap. After reset the unit is busy while it zeroes bank a; register
// writes are taken during that time.
module trail_field_diffuse_decay_unit
   import tfdd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // command channel
   input  logic              start,
   output logic              busy,
   input  req_word_type      req_word,
   // result channel
   output logic              rsp_valid,
   output rsp_word_type      rsp_word,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type       cfg;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tfdd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tfdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_word.cmd),
      .busy      (busy),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   tfdd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .req_word  (req_word),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
